// ===== hw/rtl/uue_pkg.sv =====
// uue_pkg: shared types, constants and the 6-bit character encoding
// for the uuencode line encoder. No dependencies.
`default_nettype none

package uue_pkg;

  localparam int LINE_BYTES_DFLT = 45;

  localparam logic [6:0] CHAR_NL    = 7'd10;
  localparam logic [6:0] CHAR_QUOTE = 7'd96;
  localparam logic [6:0] CHAR_SPACE = 7'd32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
    logic       stream_done;
  } out_beat_t;

  function automatic logic [6:0] enc6(input logic [5:0] v);
    enc6 = (v == 6'd0) ? CHAR_QUOTE : (CHAR_SPACE + {1'b0, v});
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/uue_ram.sv =====
// uue_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module uue_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 45,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uuencode_line_encoder.sv =====
// uuencode_line_encoder: collects bytes in a line RAM and emits uuencoded lines.
// Depends on uue_pkg and uue_ram.
// The beat that fills or ends the line moves the sequencer to S_LEN, which then registers
// the length character onto out_*. Bytes that complete no line are taken one per cycle.
// A line of n bytes is 4*ceil(n/3)+2 characters, one per cycle from the single output
// register unless out_ready stalls; the terminator line adds two. Input is held off meanwhile.
// Reset (rst_n low, synchronous) clears the byte count, sequencer and output valid.
`default_nettype none

module uuencode_line_encoder
  import uue_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DFLT
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_beat
);

  localparam int AW    = $clog2(LINE_BYTES);
  localparam int CNT_W = $clog2(LINE_BYTES + 1);
  localparam int IDX_W = $clog2(LINE_BYTES + 3);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LEN  = 6'b000010,
    S_DATA = 6'b000100,
    S_NL   = 6'b001000,
    S_TQ   = 6'b010000,
    S_TNL  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             term_r, term_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic             zero_r, zero_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_beat_r, out_beat_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] n_ext, base_p3;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       b_cur;
  logic [5:0]       v6;
  logic             accept, adv, full;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign adv       = !out_valid_r || out_ready;
  assign ram_we    = accept && in_beat.byte_present;
  assign n_ext     = IDX_W'(n_r);
  assign base_p3   = base_r + IDX_W'(3);
  assign cnt_inc   = cnt_r + CNT_W'(in_beat.byte_present);
  assign full      = in_beat.byte_present && (cnt_inc == CNT_W'(LINE_BYTES));
  assign b_cur     = zero_r ? 8'd0 : ram_rdata;
  assign ram_raddr = (rd_idx < n_ext) ? rd_idx[AW-1:0] : '0;

  always_comb begin
    case (phase_r)
      2'd0:    v6 = b_cur[7:2];
      2'd1:    v6 = {prev_r[1:0], b_cur[7:4]};
      2'd2:    v6 = {prev_r[3:0], b_cur[7:6]};
      default: v6 = b_cur[5:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    term_nxt      = term_r;
    base_nxt      = base_r;
    phase_nxt     = phase_r;
    prev_nxt      = prev_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_beat_nxt  = out_beat_r;
    ram_re        = 1'b0;
    rd_idx        = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (full) begin
            n_nxt     = CNT_W'(LINE_BYTES);
            cnt_nxt   = '0;
            term_nxt  = in_beat.end_of_input;
            state_nxt = S_LEN;
          end else if (in_beat.end_of_input) begin
            n_nxt     = cnt_inc;
            cnt_nxt   = '0;
            term_nxt  = 1'b1;
            state_nxt = (cnt_inc != '0) ? S_LEN : S_TQ;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_LEN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{out_char: enc6(6'(n_r)), run_last: 1'b0, stream_done: 1'b0};
          ram_re        = 1'b1;
          rd_idx        = '0;
          base_nxt      = '0;
          phase_nxt     = 2'd0;
          state_nxt     = S_DATA;
        end
      end
      S_DATA: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{out_char: enc6(v6), run_last: 1'b0, stream_done: 1'b0};
          phase_nxt     = phase_r + 2'd1;
          case (phase_r)
            2'd0: begin
              prev_nxt = b_cur;
              ram_re   = 1'b1;
              rd_idx   = base_r + IDX_W'(1);
            end
            2'd1: begin
              prev_nxt = b_cur;
              ram_re   = 1'b1;
              rd_idx   = base_r + IDX_W'(2);
            end
            2'd2: begin
              prev_nxt = b_cur;
            end
            default: begin
              base_nxt = base_p3;
              if (base_p3 < n_ext) begin
                ram_re = 1'b1;
                rd_idx = base_p3;
              end else begin
                state_nxt = S_NL;
              end
            end
          endcase
        end
      end
      S_NL: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{out_char: CHAR_NL, run_last: !term_r, stream_done: 1'b0};
          state_nxt     = term_r ? S_TQ : S_IDLE;
        end
      end
      S_TQ: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{out_char: CHAR_QUOTE, run_last: 1'b0, stream_done: 1'b0};
          state_nxt     = S_TNL;
        end
      end
      S_TNL: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{out_char: CHAR_NL, run_last: 1'b1, stream_done: 1'b1};
          term_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (ram_re) begin
      zero_nxt = (rd_idx >= n_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    base_r     <= base_nxt;
    phase_r    <= phase_nxt;
    prev_r     <= prev_nxt;
    zero_r     <= zero_nxt;
    out_beat_r <= out_beat_nxt;
  end

  uue_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_beat.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/uue_checker.sv =====
// uue_checker: port-level checks for uuencode_line_encoder, bound to the top level.
// Depends on uue_pkg.
`default_nettype none

module uue_checker
  import uue_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_beat_t  in_beat,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_beat
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("stalled output beat changed");

  a_done_is_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.stream_done |-> out_beat.run_last && out_beat.out_char == CHAR_NL)
    else $error("stream_done not on final newline");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.out_char == CHAR_NL ||
                  (out_beat.out_char >= CHAR_SPACE && out_beat.out_char <= CHAR_QUOTE))
    else $error("output character out of range");

  a_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_beat.end_of_input |=> !in_ready)
    else $error("input accepted right after end beat");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind uuencode_line_encoder uue_checker u_uue_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);

`default_nettype wire
